@@ hdl/axis_align_rotation_rate_macros.svh @@
// Assertion macros shared by the axis alignment rate pipeline.
`ifndef AXIS_ALIGN_ROTATION_RATE_MACROS_SVH
`define AXIS_ALIGN_ROTATION_RATE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define AARR_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AARR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/aarr_pkg.sv @@
// Shared widths, constants and types of the axis alignment rate pipeline.
package aarr_pkg;

    localparam int AXIS_W     = 16;
    localparam int PROD_W     = 32;
    localparam int CROSS_W    = 33;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 64;
    localparam int LEN_W      = 32;
    localparam int ROOT_STEPS = 32;
    localparam int UNIT_FRAC  = 24;
    localparam int QUO_STEPS  = UNIT_FRAC + 1;
    localparam int QUO_W      = UNIT_FRAC + 1;
    localparam int UNIT_W     = UNIT_FRAC + 2;
    localparam int REM_W      = LEN_W + 1;
    localparam int CORD_W     = 36;
    localparam int ZANG_W     = 26;
    localparam int ANGLE_W    = 24;
    localparam int ATAN_LEN   = 24;
    localparam int GAIN_W     = 16;
    localparam int IDX_W      = 2;

    // 180 and 90 degrees in Q.16
    localparam logic [ANGLE_W-1:0]       ANGLE_MAX   = 24'd11796480;
    localparam logic signed [ZANG_W-1:0] RIGHT_ANGLE = 26'sd5898240;

    // atan(2^-i) in Q.16 degrees, rounded to nearest
    localparam logic signed [ZANG_W-1:0] ATAN_Q16 [ATAN_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef logic [IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_DAMPING     = 2'd0;
    localparam t_reg_idx REG_ANGLE_GAIN  = 2'd1;
    localparam t_reg_idx REG_SPEED_LIMIT = 2'd2;

    // Per-item control carried from the divider into the rate stages
    typedef struct packed {
        logic valid;
        logic zero;
    } t_flow;

endpackage

@@ hdl/aarr_req_if.sv @@
// Request channel: two axes and the current angular speed.
interface aarr_req_if #(
    parameter int SPEED_BITS = 24
) ();
    logic                   valid;
    logic                   ready;
    logic signed [15:0]     test_x;
    logic signed [15:0]     test_y;
    logic signed [15:0]     test_z;
    logic signed [15:0]     target_x;
    logic signed [15:0]     target_y;
    logic signed [15:0]     target_z;
    logic signed [SPEED_BITS-1:0] spin_x;
    logic signed [SPEED_BITS-1:0] spin_y;
    logic signed [SPEED_BITS-1:0] spin_z;

    modport source (
        output valid, test_x, test_y, test_z, target_x, target_y, target_z,
               spin_x, spin_y, spin_z,
        input  ready
    );
    modport sink (
        input  valid, test_x, test_y, test_z, target_x, target_y, target_z,
               spin_x, spin_y, spin_z,
        output ready
    );
endinterface

@@ hdl/aarr_rsp_if.sv @@
// Response channel: commanded rotation speed.
interface aarr_rsp_if #(
    parameter int SPEED_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] rate_x;
    logic signed [SPEED_BITS-1:0] rate_y;
    logic signed [SPEED_BITS-1:0] rate_z;

    modport source (output valid, rate_x, rate_y, rate_z, input ready);
    modport sink (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

@@ hdl/aarr_front.sv @@
// Front stages: products, cross and dot, squared cross length.
module aarr_front #(
    parameter int SPEED_BITS = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic signed [aarr_pkg::AXIS_W-1:0]         i_t [3],
    input  logic signed [aarr_pkg::AXIS_W-1:0]         i_g [3],
    input  logic signed [SPEED_BITS-1:0]               i_s [3],
    output logic                                       o_valid,
    output logic [aarr_pkg::SQ_W-1:0]                  o_sq,
    output logic signed [aarr_pkg::CROSS_W-1:0]        o_c [3],
    output logic signed [aarr_pkg::CROSS_W-1:0]        o_dot,
    output logic signed [SPEED_BITS-1:0]               o_s [3]
);
    localparam int NS = 4;

    logic                                r_v [NS];
    logic signed [SPEED_BITS-1:0]        r_s [NS][3];
    logic signed [aarr_pkg::PROD_W-1:0]  r_p1 [9];
    logic signed [aarr_pkg::CROSS_W-1:0] r_c2 [3];
    logic signed [aarr_pkg::CROSS_W-1:0] r_dot2;
    logic signed [aarr_pkg::CROSS_W-1:0] r_c3 [3];
    logic signed [aarr_pkg::CROSS_W-1:0] r_dot3;
    logic [aarr_pkg::SQ_W-1:0]           r_sqr3 [3];
    logic signed [aarr_pkg::CROSS_W-1:0] r_c4 [3];
    logic signed [aarr_pkg::CROSS_W-1:0] r_dot4;
    logic [aarr_pkg::SQ_W-1:0]           r_sq4;
    logic [aarr_pkg::MAG_W-1:0]          n_mag [3];

    // Magnitudes of the cross components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_c2[i][aarr_pkg::CROSS_W-1] ? aarr_pkg::MAG_W'(-r_c2[i])
                                                    : r_c2[i][aarr_pkg::MAG_W-1:0];
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < NS; j++) r_v[j] <= r_v[j-1];
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= i_s;
            for (int j = 1; j < NS; j++) r_s[j] <= r_s[j-1];
            // stage 1: the nine axis products
            r_p1[0] <= i_t[1] * i_g[2];
            r_p1[1] <= i_t[2] * i_g[1];
            r_p1[2] <= i_t[2] * i_g[0];
            r_p1[3] <= i_t[0] * i_g[2];
            r_p1[4] <= i_t[0] * i_g[1];
            r_p1[5] <= i_t[1] * i_g[0];
            r_p1[6] <= i_t[0] * i_g[0];
            r_p1[7] <= i_t[1] * i_g[1];
            r_p1[8] <= i_t[2] * i_g[2];
            // stage 2: cross and dot
            r_c2[0] <= aarr_pkg::CROSS_W'(r_p1[0]) - aarr_pkg::CROSS_W'(r_p1[1]);
            r_c2[1] <= aarr_pkg::CROSS_W'(r_p1[2]) - aarr_pkg::CROSS_W'(r_p1[3]);
            r_c2[2] <= aarr_pkg::CROSS_W'(r_p1[4]) - aarr_pkg::CROSS_W'(r_p1[5]);
            r_dot2  <= aarr_pkg::CROSS_W'(r_p1[6]) + aarr_pkg::CROSS_W'(r_p1[7])
                     + aarr_pkg::CROSS_W'(r_p1[8]);
            // stage 3: squares
            r_c3   <= r_c2;
            r_dot3 <= r_dot2;
            for (int i = 0; i < 3; i++) r_sqr3[i] <= n_mag[i] * n_mag[i];
            // stage 4: sum of squares
            r_c4   <= r_c3;
            r_dot4 <= r_dot3;
            r_sq4  <= r_sqr3[0] + r_sqr3[1] + r_sqr3[2];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_sq    = r_sq4;
    assign o_c     = r_c4;
    assign o_dot   = r_dot4;
    assign o_s     = r_s[NS-1];
endmodule

@@ hdl/aarr_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`include "axis_align_rotation_rate_macros.svh"
module aarr_sqrt #(
    parameter int SPEED_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [aarr_pkg::SQ_W-1:0]           i_sq,
    input  logic signed [aarr_pkg::CROSS_W-1:0] i_c [3],
    input  logic signed [aarr_pkg::CROSS_W-1:0] i_dot,
    input  logic signed [SPEED_BITS-1:0]        i_s [3],
    output logic                                o_valid,
    output logic [aarr_pkg::LEN_W-1:0]          o_len,
    output logic signed [aarr_pkg::CROSS_W-1:0] o_c [3],
    output logic signed [aarr_pkg::CROSS_W-1:0] o_dot,
    output logic signed [SPEED_BITS-1:0]        o_s [3]
);
    localparam int N  = aarr_pkg::ROOT_STEPS;
    localparam int SW = aarr_pkg::SQ_W;

    logic                                r_v    [N];
    logic [SW-1:0]                       r_rem  [N];
    logic [SW-1:0]                       r_root [N];
    logic signed [aarr_pkg::CROSS_W-1:0] r_c    [N][3];
    logic signed [aarr_pkg::CROSS_W-1:0] r_dot  [N];
    logic signed [SPEED_BITS-1:0]        r_s    [N][3];

    logic [SW-1:0] a_rem  [N];
    logic [SW-1:0] a_root [N];
    logic [SW-1:0] n_rem  [N];
    logic [SW-1:0] n_root [N];
    logic [SW:0]   trial;
    logic [SW-1:0] bitv;

    // One root bit per stage, trial bit walks down by two
    always_comb begin
        a_rem[0]  = i_sq;
        a_root[0] = '0;
        for (int j = 1; j < N; j++) begin
            a_rem[j]  = r_rem[j-1];
            a_root[j] = r_root[j-1];
        end
        trial = '0;
        bitv  = '0;
        for (int j = 0; j < N; j++) begin
            bitv  = SW'(1) << (SW - 2 - 2 * j);
            trial = {1'b0, a_root[j]} + {1'b0, bitv};
            if ({1'b0, a_rem[j]} >= trial) begin
                n_rem[j]  = a_rem[j] - trial[SW-1:0];
                n_root[j] = (a_root[j] >> 1) + bitv;
            end else begin
                n_rem[j]  = a_rem[j];
                n_root[j] = a_root[j] >> 1;
            end
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < N; j++) r_v[j] <= r_v[j-1];
        end
    end

    // Root stages and side data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_c[0]   <= i_c;
            r_dot[0] <= i_dot;
            r_s[0]   <= i_s;
            for (int j = 1; j < N; j++) begin
                r_c[j]   <= r_c[j-1];
                r_dot[j] <= r_dot[j-1];
                r_s[j]   <= r_s[j-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_len   = r_root[N-1][aarr_pkg::LEN_W-1:0];
    assign o_c     = r_c[N-1];
    assign o_dot   = r_dot[N-1];
    assign o_s     = r_s[N-1];

    // leftover must not exceed twice the root, else a bit was missed
    `AARR_ASSERT_IMPLIES(a_root_rem, i_clk, i_rst_n, r_v[N-1], r_rem[N-1] <= {r_root[N-1][SW-2:0], 1'b0}, "sqrt remainder out of range")
endmodule

@@ hdl/aarr_divcord.sv @@
// Unit-axis dividers and angle CORDIC, one step per stage side by side.
`include "axis_align_rotation_rate_macros.svh"
module aarr_divcord #(
    parameter int SPEED_BITS  = 24,
    parameter int ANGLE_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [aarr_pkg::LEN_W-1:0]          i_len,
    input  logic signed [aarr_pkg::CROSS_W-1:0] i_c [3],
    input  logic signed [aarr_pkg::CROSS_W-1:0] i_dot,
    input  logic signed [SPEED_BITS-1:0]        i_s [3],
    output aarr_pkg::t_flow                     o_flow,
    output logic [aarr_pkg::QUO_W-1:0]          o_q [3],
    output logic                                o_neg [3],
    output logic signed [aarr_pkg::ZANG_W-1:0]  o_z,
    output logic signed [SPEED_BITS-1:0]        o_s [3]
);
    localparam int Q     = aarr_pkg::QUO_STEPS;
    localparam int STEPS = (ANGLE_STEPS < aarr_pkg::ATAN_LEN) ? ANGLE_STEPS
                                                              : aarr_pkg::ATAN_LEN;
    localparam int RW    = aarr_pkg::REM_W;
    localparam int CW    = aarr_pkg::CORD_W;
    localparam int ZW    = aarr_pkg::ZANG_W;
    localparam int LW    = aarr_pkg::LEN_W;
    localparam int QW    = aarr_pkg::QUO_W;

    // prep stage
    logic                         r_pv;
    logic                         r_pzero;
    logic                         r_pneg [3];
    logic [aarr_pkg::MAG_W-1:0]   r_pmag [3];
    logic [LW-1:0]                r_plen;
    logic signed [CW-1:0]         r_px;
    logic signed [CW-1:0]         r_py;
    logic signed [ZW-1:0]         r_pz;
    logic signed [SPEED_BITS-1:0] r_ps [3];

    // step stages
    logic                         r_v    [Q];
    logic                         r_zero [Q];
    logic                         r_neg  [Q][3];
    logic [RW-1:0]                r_rem  [Q][3];
    logic [QW-1:0]                r_q    [Q][3];
    logic [LW-1:0]                r_len  [Q];
    logic signed [CW-1:0]         r_x    [Q];
    logic signed [CW-1:0]         r_y    [Q];
    logic signed [ZW-1:0]         r_z    [Q];
    logic signed [SPEED_BITS-1:0] r_s    [Q][3];

    logic [RW-1:0]        a_rem [Q][3];
    logic [QW-1:0]        a_q   [Q][3];
    logic [LW-1:0]        a_len [Q];
    logic signed [CW-1:0] a_x   [Q];
    logic signed [CW-1:0] a_y   [Q];
    logic signed [ZW-1:0] a_z   [Q];
    logic [RW-1:0]        n_rem [Q][3];
    logic [QW-1:0]        n_q   [Q][3];
    logic signed [CW-1:0] n_x   [Q];
    logic signed [CW-1:0] n_y   [Q];
    logic signed [ZW-1:0] n_z   [Q];
    logic [RW-1:0]        shifted;
    logic                 fits;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    logic signed [CW-1:0] n_dot_ext;
    logic signed [CW-1:0] n_len_ext;

    assign n_dot_ext = CW'(i_dot);
    assign n_len_ext = $signed({{(CW-LW){1'b0}}, i_len});

    // Stage inputs: first from prep, then from the previous step
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_rem[0][i] = {1'b0, r_pmag[i]};
            a_q[0][i]   = '0;
        end
        a_len[0] = r_plen;
        a_x[0]   = r_px;
        a_y[0]   = r_py;
        a_z[0]   = r_pz;
        for (int j = 1; j < Q; j++) begin
            for (int i = 0; i < 3; i++) begin
                a_rem[j][i] = r_rem[j-1][i];
                a_q[j][i]   = r_q[j-1][i];
            end
            a_len[j] = r_len[j-1];
            a_x[j]   = r_x[j-1];
            a_y[j]   = r_y[j-1];
            a_z[j]   = r_z[j-1];
        end
    end

    // Restoring division step and CORDIC vectoring step
    always_comb begin
        shifted = '0;
        fits    = 1'b0;
        dx      = '0;
        dy      = '0;
        for (int j = 0; j < Q; j++) begin
            for (int i = 0; i < 3; i++) begin
                shifted = (j == 0) ? a_rem[j][i] : {a_rem[j][i][RW-2:0], 1'b0};
                fits    = shifted >= {1'b0, a_len[j]};
                n_rem[j][i] = fits ? shifted - {1'b0, a_len[j]} : shifted;
                n_q[j][i]   = {a_q[j][i][QW-2:0], fits};
            end
            if (j < STEPS) begin
                dx = a_y[j] >>> j;
                dy = a_x[j] >>> j;
                if (a_y[j] > 0) begin
                    n_x[j] = a_x[j] + dx;
                    n_y[j] = a_y[j] - dy;
                    n_z[j] = a_z[j] + aarr_pkg::ATAN_Q16[j];
                end else begin
                    n_x[j] = a_x[j] - dx;
                    n_y[j] = a_y[j] + dy;
                    n_z[j] = a_z[j] - aarr_pkg::ATAN_Q16[j];
                end
            end else begin
                n_x[j] = a_x[j];
                n_y[j] = a_y[j];
                n_z[j] = a_z[j];
            end
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            for (int j = 0; j < Q; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_v[0] <= r_pv;
            for (int j = 1; j < Q; j++) r_v[j] <= r_v[j-1];
        end
    end

    // Prep: magnitudes and signs, quarter turn when the dot is negative
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pzero <= (i_len == '0);
            r_plen  <= i_len;
            r_ps    <= i_s;
            for (int i = 0; i < 3; i++) begin
                r_pneg[i] <= i_c[i][aarr_pkg::CROSS_W-1];
                r_pmag[i] <= i_c[i][aarr_pkg::CROSS_W-1]
                           ? aarr_pkg::MAG_W'(-i_c[i]) : i_c[i][aarr_pkg::MAG_W-1:0];
            end
            if (i_dot[aarr_pkg::CROSS_W-1]) begin
                r_px <= n_len_ext;
                r_py <= -n_dot_ext;
                r_pz <= aarr_pkg::RIGHT_ANGLE;
            end else begin
                r_px <= n_dot_ext;
                r_py <= n_len_ext;
                r_pz <= '0;
            end
        end
    end

    // Step registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_len <= a_len;
            r_zero[0] <= r_pzero;
            r_neg[0]  <= r_pneg;
            r_s[0]    <= r_ps;
            for (int j = 1; j < Q; j++) begin
                r_zero[j] <= r_zero[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_s[j]    <= r_s[j-1];
            end
        end
    end

    assign o_flow.valid = r_v[Q-1];
    assign o_flow.zero  = r_zero[Q-1];
    assign o_q          = r_q[Q-1];
    assign o_neg        = r_neg[Q-1];
    assign o_z          = r_z[Q-1];
    assign o_s          = r_s[Q-1];

    // a remainder at or above the divisor means a quotient bit was dropped
    `AARR_ASSERT_IMPLIES(a_div_rem, i_clk, i_rst_n, r_v[Q-1] && !r_zero[Q-1], r_rem[Q-1][0] < {1'b0, r_len[Q-1]}, "divider remainder not below length")
endmodule

@@ hdl/aarr_rate.sv @@
// Rate stages: projection, gains, clamp and scaled axis, with output register.
`include "axis_align_rotation_rate_macros.svh"
module aarr_rate #(
    parameter int SPEED_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  aarr_pkg::t_flow                     i_flow,
    input  logic [aarr_pkg::QUO_W-1:0]          i_q [3],
    input  logic                                i_neg [3],
    input  logic signed [aarr_pkg::ZANG_W-1:0]  i_z,
    input  logic signed [SPEED_BITS-1:0]        i_s [3],
    input  logic [aarr_pkg::GAIN_W-1:0]         i_damping,
    input  logic [aarr_pkg::GAIN_W-1:0]         i_angle_gain,
    input  logic [SPEED_BITS-2:0]               i_limit,
    output logic                                o_valid,
    output logic signed [SPEED_BITS-1:0]        o_rate [3]
);
    localparam int NS  = 7;
    localparam int UW  = aarr_pkg::UNIT_W;
    localparam int AW  = aarr_pkg::ANGLE_W;
    localparam int GW  = aarr_pkg::GAIN_W;
    localparam int SUW = SPEED_BITS + UW;
    localparam int PJW = SUW + 2 - aarr_pkg::UNIT_FRAC;
    localparam int AGW = GW + AW - 8;
    localparam int DPW = GW + 1 + PJW;
    localparam int KW  = SPEED_BITS + 22;
    localparam int KCW = SPEED_BITS + 8;
    localparam int PW  = UW + KCW;
    localparam int SH  = aarr_pkg::UNIT_FRAC + 8;

    logic                     r_v    [NS];
    logic                     r_zero [NS];
    logic signed [UW-1:0]     r_u1 [3];
    logic [AW-1:0]            r_ang1;
    logic signed [SPEED_BITS-1:0] r_s1 [3];
    logic signed [UW-1:0]     r_u2 [3];
    logic [AW-1:0]            r_ang2;
    logic signed [SUW-1:0]    r_su2 [3];
    logic signed [UW-1:0]     r_u3 [3];
    logic [AGW-1:0]           r_ag3;
    logic signed [PJW-1:0]    r_proj3;
    logic signed [UW-1:0]     r_u4 [3];
    logic [AGW-1:0]           r_ag4;
    logic signed [DPW-1:0]    r_dp4;
    logic signed [UW-1:0]     r_u5 [3];
    logic signed [KCW-1:0]    r_k5;
    logic signed [PW-1:0]     r_p6 [3];
    logic signed [SPEED_BITS-1:0] r_rate7 [3];

    logic signed [UW-1:0]     n_u [3];
    logic [AW-1:0]            n_ang;
    logic signed [SUW+1:0]    n_sum;
    logic [GW+AW-1:0]         n_agfull;
    logic signed [KW-1:0]     n_k;
    logic signed [KCW-1:0]    n_lim;
    logic signed [KCW-1:0]    n_kc;

    // Signed unit axis and angle clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = i_neg[i] ? -$signed({1'b0, i_q[i]}) : $signed({1'b0, i_q[i]});
        end
        if (i_z < 0) begin
            n_ang = '0;
        end else if (i_z > $signed({2'b00, aarr_pkg::ANGLE_MAX})) begin
            n_ang = aarr_pkg::ANGLE_MAX;
        end else begin
            n_ang = i_z[AW-1:0];
        end
    end

    // Projection sum, angle term, signed rate and its clamp
    always_comb begin
        n_sum    = (SUW+2)'(r_su2[0]) + (SUW+2)'(r_su2[1]) + (SUW+2)'(r_su2[2]);
        n_agfull = i_angle_gain * r_ang2;
        n_k      = $signed({{(KW-AGW){1'b0}}, r_ag4}) - KW'(r_dp4);
        n_lim    = $signed({1'b0, i_limit, 8'd0});
        if (n_k > KW'(n_lim)) begin
            n_kc = n_lim;
        end else if (n_k < -KW'(n_lim)) begin
            n_kc = -n_lim;
        end else begin
            n_kc = n_k[KCW-1:0];
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_flow.valid;
            for (int j = 1; j < NS; j++) r_v[j] <= r_v[j-1];
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_flow.zero;
            for (int j = 1; j < NS; j++) r_zero[j] <= r_zero[j-1];
            r_u1   <= n_u;
            r_ang1 <= n_ang;
            r_s1   <= i_s;
            r_u2   <= r_u1;
            r_ang2 <= r_ang1;
            for (int i = 0; i < 3; i++) r_su2[i] <= r_s1[i] * r_u1[i];
            r_u3    <= r_u2;
            r_ag3   <= n_agfull[GW+AW-1:8];
            r_proj3 <= n_sum[SUW+1:aarr_pkg::UNIT_FRAC];
            r_u4    <= r_u3;
            r_ag4   <= r_ag3;
            r_dp4   <= $signed({1'b0, i_damping}) * r_proj3;
            r_u5    <= r_u4;
            r_k5    <= n_kc;
            for (int i = 0; i < 3; i++) r_p6[i] <= r_u5[i] * r_k5;
            for (int i = 0; i < 3; i++) begin
                r_rate7[i] <= r_zero[5] ? '0 : r_p6[i][SH+SPEED_BITS-1:SH];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_rate  = r_rate7;

    // clamped rate stays inside the configured limit
    `AARR_ASSERT_HOLDS(a_rate_clamp, i_clk, i_rst_n, !r_v[4] || (KW'(r_k5) <= KW'(n_lim) && KW'(r_k5) >= -KW'(n_lim)), "clamped rate exceeds limit")
endmodule

@@ hdl/axis_align_rotation_rate.sv @@
// Top level of the axis alignment rotation rate pipeline.
//
//  Channel   Dir  Payload                                   Handshake
//  i_req     in   test_*, target_* Q1.14; spin_* Q15.8      valid / ready
//  o_rsp     out  rate_* Q15.8 deg/s                        valid / ready
//  i_cfg_*   in   idx 0 damping, 1 angle gain, 2 limit      write enable only
//
// One request is taken every cycle unless the output stalls; the path has 4 front stages,
// 32 square-root stages (one root bit each), 1 prep stage, 25 divider stages
// (one quotient bit each, CORDIC steps in parallel) and 7 rate stages.
// Reset clears valid bits and sets the registers to damping 1.0, gain 1.0,
// full-scale limit. A stalled output freezes the whole pipeline in place.
module axis_align_rotation_rate #(
    parameter int SPEED_BITS  = 24,
    parameter int ANGLE_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aarr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [((SPEED_BITS-1 > aarr_pkg::GAIN_W) ? SPEED_BITS-1
                   : aarr_pkg::GAIN_W)-1:0] i_cfg_data,
    aarr_req_if.sink                      i_req,
    aarr_rsp_if.source                    o_rsp
);
    logic [aarr_pkg::GAIN_W-1:0] r_damping;
    logic [aarr_pkg::GAIN_W-1:0] r_angle_gain;
    logic [SPEED_BITS-2:0]       r_limit;

    logic en;
    logic signed [aarr_pkg::AXIS_W-1:0] t_in [3];
    logic signed [aarr_pkg::AXIS_W-1:0] g_in [3];
    logic signed [SPEED_BITS-1:0]       s_in [3];

    logic                                f_valid;
    logic [aarr_pkg::SQ_W-1:0]           f_sq;
    logic signed [aarr_pkg::CROSS_W-1:0] f_c [3];
    logic signed [aarr_pkg::CROSS_W-1:0] f_dot;
    logic signed [SPEED_BITS-1:0]        f_s [3];

    logic                                q_valid;
    logic [aarr_pkg::LEN_W-1:0]          q_len;
    logic signed [aarr_pkg::CROSS_W-1:0] q_c [3];
    logic signed [aarr_pkg::CROSS_W-1:0] q_dot;
    logic signed [SPEED_BITS-1:0]        q_s [3];

    aarr_pkg::t_flow                     d_flow;
    logic [aarr_pkg::QUO_W-1:0]          d_q [3];
    logic                                d_neg [3];
    logic signed [aarr_pkg::ZANG_W-1:0]  d_z;
    logic signed [SPEED_BITS-1:0]        d_s [3];

    logic                                r_out_valid;
    logic signed [SPEED_BITS-1:0]        rate [3];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping    <= aarr_pkg::GAIN_W'(256);
            r_angle_gain <= aarr_pkg::GAIN_W'(256);
            r_limit      <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aarr_pkg::REG_DAMPING:     r_damping    <= i_cfg_data[aarr_pkg::GAIN_W-1:0];
                aarr_pkg::REG_ANGLE_GAIN:  r_angle_gain <= i_cfg_data[aarr_pkg::GAIN_W-1:0];
                aarr_pkg::REG_SPEED_LIMIT: r_limit      <= i_cfg_data[SPEED_BITS-2:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless a result waits at the output
    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    assign t_in[0] = i_req.test_x;
    assign t_in[1] = i_req.test_y;
    assign t_in[2] = i_req.test_z;
    assign g_in[0] = i_req.target_x;
    assign g_in[1] = i_req.target_y;
    assign g_in[2] = i_req.target_z;
    assign s_in[0] = i_req.spin_x;
    assign s_in[1] = i_req.spin_y;
    assign s_in[2] = i_req.spin_z;

    aarr_front #(.SPEED_BITS(SPEED_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_t     (t_in),
        .i_g     (g_in),
        .i_s     (s_in),
        .o_valid (f_valid),
        .o_sq    (f_sq),
        .o_c     (f_c),
        .o_dot   (f_dot),
        .o_s     (f_s)
    );

    aarr_sqrt #(.SPEED_BITS(SPEED_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_sq    (f_sq),
        .i_c     (f_c),
        .i_dot   (f_dot),
        .i_s     (f_s),
        .o_valid (q_valid),
        .o_len   (q_len),
        .o_c     (q_c),
        .o_dot   (q_dot),
        .o_s     (q_s)
    );

    aarr_divcord #(.SPEED_BITS(SPEED_BITS), .ANGLE_STEPS(ANGLE_STEPS)) u_divcord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_len   (q_len),
        .i_c     (q_c),
        .i_dot   (q_dot),
        .i_s     (q_s),
        .o_flow  (d_flow),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_z     (d_z),
        .o_s     (d_s)
    );

    aarr_rate #(.SPEED_BITS(SPEED_BITS)) u_rate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_flow       (d_flow),
        .i_q          (d_q),
        .i_neg        (d_neg),
        .i_z          (d_z),
        .i_s          (d_s),
        .i_damping    (r_damping),
        .i_angle_gain (r_angle_gain),
        .i_limit      (r_limit),
        .o_valid      (r_out_valid),
        .o_rate       (rate)
    );

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.rate_x = rate[0];
    assign o_rsp.rate_y = rate[1];
    assign o_rsp.rate_z = rate[2];
endmodule

@@ bench/tb_axis_align_rotation_rate.sv @@
// Self-checking bench for the axis alignment rotation rate pipeline.
`timescale 1ns / 1ps

module tb_axis_align_rotation_rate;

    localparam int SPEED_BITS  = 24;
    localparam int ANGLE_STEPS = 16;
    localparam int CFG_W       = SPEED_BITS - 1;
    localparam int AXIS_W      = aarr_pkg::AXIS_W;
    localparam int LATENCY     = 69;
    localparam int CORDIC_N    = (ANGLE_STEPS > aarr_pkg::ATAN_LEN) ? aarr_pkg::ATAN_LEN
                                                                    : ANGLE_STEPS;
    localparam aarr_pkg::t_reg_idx REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [AXIS_W-1:0]     tv [3];
        logic signed [AXIS_W-1:0]     gv [3];
        logic signed [SPEED_BITS-1:0] sv [3];
    } t_align_req;

    typedef struct {
        logic signed [SPEED_BITS-1:0] r [3];
    } t_rate;

    // Predicts commanded rates and holds them until the pipeline delivers
    class rate_scoreboard;
        logic [aarr_pkg::GAIN_W-1:0] damping;
        logic [aarr_pkg::GAIN_W-1:0] gain;
        logic [CFG_W-1:0]            limit;
        t_rate                       pending_rates[$];
        int                          errors;
        int                          checked;

        function new();
            damping = 16'd256;
            gain    = 16'd256;
            limit   = '1;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(aarr_pkg::t_reg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                aarr_pkg::REG_DAMPING:     damping = value[aarr_pkg::GAIN_W-1:0];
                aarr_pkg::REG_ANGLE_GAIN:  gain    = value[aarr_pkg::GAIN_W-1:0];
                aarr_pkg::REG_SPEED_LIMIT: limit   = value;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned res, bitv;
            res  = '0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   -= res + bitv;
                    res  = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Vectoring CORDIC on (dot, len), degrees in Q.16
        function longint error_angle(longint x, longint y);
            longint z, dx, dy, tmp;
            z = '0;
            if (x < 0) begin
                tmp = x;
                x   = y;
                y   = -tmp;
                z   = longint'(aarr_pkg::RIGHT_ANGLE);
            end
            for (int i = 0; i < CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(aarr_pkg::ATAN_Q16[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(aarr_pkg::ATAN_Q16[i]);
                end
            end
            if (z < 0) z = '0;
            if (z > longint'(aarr_pkg::ANGLE_MAX)) z = longint'(aarr_pkg::ANGLE_MAX);
            return z;
        endfunction

        function void note_request(t_align_req q);
            longint t[3], g[3], s[3], c[3], u[3];
            longint dotp, ang, proj, k, lim;
            longint unsigned sq, len, m;
            t_rate exp_rate;
            for (int i = 0; i < 3; i++) begin
                t[i] = longint'(q.tv[i]);
                g[i] = longint'(q.gv[i]);
                s[i] = longint'(q.sv[i]);
            end
            c[0] = t[1] * g[2] - t[2] * g[1];
            c[1] = t[2] * g[0] - t[0] * g[2];
            c[2] = t[0] * g[1] - t[1] * g[0];
            dotp = t[0] * g[0] + t[1] * g[1] + t[2] * g[2];
            sq = '0;
            for (int i = 0; i < 3; i++) begin
                m   = (c[i] < 0) ? -c[i] : c[i];
                sq += m * m;
            end
            len = root_floor(sq);
            if (len == 0) begin
                for (int i = 0; i < 3; i++) exp_rate.r[i] = '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    m    = (c[i] < 0) ? -c[i] : c[i];
                    u[i] = longint'((m << aarr_pkg::UNIT_FRAC) / len);
                    if (c[i] < 0) u[i] = -u[i];
                end
                ang  = error_angle(dotp, longint'(len));
                proj = (s[0] * u[0] + s[1] * u[1] + s[2] * u[2]) >>> aarr_pkg::UNIT_FRAC;
                k    = ((longint'(gain) * ang) >>> 8) - longint'(damping) * proj;
                lim  = longint'(limit) * 256;
                if (k > lim)  k = lim;
                if (k < -lim) k = -lim;
                for (int i = 0; i < 3; i++)
                    exp_rate.r[i] = SPEED_BITS'((u[i] * k) >>> (aarr_pkg::UNIT_FRAC + 8));
            end
            pending_rates.push_back(exp_rate);
        endfunction

        function void check_rate(t_rate got);
            t_rate want;
            if (pending_rates.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         got.r[0], got.r[1], got.r[2]);
                errors++;
                return;
            end
            want = pending_rates.pop_front();
            checked++;
            for (int i = 0; i < 3; i++)
                if (got.r[i] !== want.r[i]) begin
                    $display("%0t: rate[%0d] expected %0d actual %0d", $time, i,
                             want.r[i], got.r[i]);
                    errors++;
                end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    aarr_pkg::t_reg_idx   i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    bit                   calm;
    int                   sent;

    aarr_req_if #(.SPEED_BITS(SPEED_BITS)) req_ch ();
    aarr_rsp_if #(.SPEED_BITS(SPEED_BITS)) rsp_ch ();

    rate_scoreboard sb = new();

    axis_align_rotation_rate #(
        .SPEED_BITS (SPEED_BITS),
        .ANGLE_STEPS(ANGLE_STEPS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_ch.sink),
        .o_rsp     (rsp_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: check each transfer, then pick next ready
    always @(posedge i_clk) begin
        t_rate got;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.r[0] = rsp_ch.rate_x;
                got.r[1] = rsp_ch.rate_y;
                got.r[2] = rsp_ch.rate_z;
                sb.check_rate(got);
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // One request transfer; valid stays high into the next call unless a gap follows
    task automatic send_req(t_align_req q);
        req_ch.valid    <= 1'b1;
        req_ch.test_x   <= q.tv[0]; req_ch.test_y   <= q.tv[1]; req_ch.test_z   <= q.tv[2];
        req_ch.target_x <= q.gv[0]; req_ch.target_y <= q.gv[1]; req_ch.target_z <= q.gv[2];
        req_ch.spin_x   <= q.sv[0]; req_ch.spin_y   <= q.sv[1]; req_ch.spin_z   <= q.sv[2];
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(q);
        sent++;
        // one-cycle gaps after about 39 of 100 transfers idle the request side
        if (!calm && $urandom_range(99) < 39) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(aarr_pkg::t_reg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        i_cfg_we   <= 1'b0;
    endtask

    // Let the pipeline drain completely
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_align_req make_req(int t0, int t1, int t2, int g0, int g1, int g2,
                                            int s0, int s1, int s2);
        t_align_req q;
        q.tv[0] = AXIS_W'(t0); q.tv[1] = AXIS_W'(t1); q.tv[2] = AXIS_W'(t2);
        q.gv[0] = AXIS_W'(g0); q.gv[1] = AXIS_W'(g1); q.gv[2] = AXIS_W'(g2);
        q.sv[0] = SPEED_BITS'(s0); q.sv[1] = SPEED_BITS'(s1); q.sv[2] = SPEED_BITS'(s2);
        return q;
    endfunction

    // Random direction scaled to Q1.14 unit length
    function automatic void unit_axis(output logic signed [AXIS_W-1:0] v [3]);
        real a[3], n;
        do begin
            for (int i = 0; i < 3; i++) a[i] = $itor($urandom_range(2000)) - 1000.0;
            n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        end while (n < 1.0);
        for (int i = 0; i < 3; i++) v[i] = AXIS_W'($rtoi(a[i] / n * 16384.0));
    endfunction

    function automatic t_align_req rand_req();
        t_align_req q;
        int mode;
        mode = int'($urandom_range(99));
        unit_axis(q.tv);
        unit_axis(q.gv);
        if (mode < 8) begin
            // raw noise over the full field widths
            for (int i = 0; i < 3; i++) begin
                q.tv[i] = AXIS_W'($urandom);
                q.gv[i] = AXIS_W'($urandom);
            end
        end else if (mode < 14) begin
            // parallel or antiparallel pair
            for (int i = 0; i < 3; i++)
                q.gv[i] = mode[0] ? q.tv[i] : -q.tv[i];
        end else if (mode < 24) begin
            // nearly aligned pair
            for (int i = 0; i < 3; i++)
                q.gv[i] = AXIS_W'(int'(q.tv[i]) + int'($urandom_range(40)) - 20);
        end
        for (int i = 0; i < 3; i++)
            q.sv[i] = ($urandom_range(1) != 0) ? SPEED_BITS'($urandom)
                                               : SPEED_BITS'(int'($urandom_range(20000)) - 10000);
        return q;
    endfunction

    initial begin
        t_align_req q;
        logic [CFG_W-1:0] cfg_set [6][3];
        calm         = 1'b0;
        sent         = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = aarr_pkg::REG_DAMPING;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.test_x = '0; req_ch.test_y = '0; req_ch.test_z = '0;
        req_ch.target_x = '0; req_ch.target_y = '0; req_ch.target_z = '0;
        req_ch.spin_x = '0; req_ch.spin_y = '0; req_ch.spin_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes and degenerate axes
        send_req(make_req(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
        send_req(make_req(16384, 0, 0, 16384, 0, 0, 1000, 0, 0));       // parallel
        send_req(make_req(16384, 0, 0, -16384, 0, 0, 0, 5000, 0));      // antiparallel
        send_req(make_req(0, 0, 0, 0, 16384, 0, 0, 0, 0));              // zero axis
        send_req(make_req(16384, 0, 0, -16384, 1, 0, 0, 0, 0));         // near 180
        send_req(make_req(16384, 0, 0, 16384, 1, 0, 0, 0, 0));          // near 0
        send_req(make_req(-16384, 0, 0, 11585, 11585, 0, 0, 0, 256));   // obtuse
        send_req(make_req(0, 16384, 0, 0, 0, -16384, 8388607, 8388607, 8388607));
        send_req(make_req(0, 0, 16384, 16384, 0, 0, -8388608, -8388608, -8388608));
        send_req(make_req(-32768, -32768, -32768, 32767, -32768, 32767, 0, 0, -8388608));
        send_req(make_req(32767, 32767, -32768, -32768, 32767, 32767, 8388607, 0, 0));
        send_req(make_req(-32768, 0, 0, 0, -32768, 0, -1, -1, -1));
        send_req(make_req(1, 0, 0, 0, 1, 0, 0, 0, 0));
        send_req(make_req(-1, -1, -1, 1, 1, -1, 1, 1, 1));
        drain();

        // Settings per phase: damping, angle gain, limit
        cfg_set[0] = '{23'd0, 23'd0, 23'd0};
        cfg_set[1] = '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF};   // gains mask to 16 bits
        cfg_set[2] = '{23'd256, 23'd1024, 23'd1000};
        cfg_set[3] = '{23'd65535, 23'd1, 23'd8388607};
        cfg_set[4] = '{23'd0, 23'd65535, 23'd1};
        cfg_set[5] = '{23'd512, 23'd256, 23'd46080};
        for (int p = 0; p < 6; p++) begin
            write_reg(aarr_pkg::REG_DAMPING, cfg_set[p][0]);
            write_reg(aarr_pkg::REG_ANGLE_GAIN, cfg_set[p][1]);
            write_reg(aarr_pkg::REG_SPEED_LIMIT, cfg_set[p][2]);
            write_reg(REG_UNUSED, CFG_W'($urandom));   // must be ignored
            for (int n = 0; n < 100; n++) begin
                calm = (p == 2 && n >= 30 && n < 70);
                send_req(rand_req());
            end
            calm = 1'b0;
            drain();
        end

        $display("Sent %0d requests over 7 register settings, %0d results checked",
                 sent, sb.checked);
        $display("Covered degenerate, obtuse, full-scale and random axes with stalls");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
